@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sgp_pkg.sv @@
// ----------------------------------------------------------------------------
// sgp_pkg
// Widths, constants and shared types of the sliding Goertzel power detector.
// ----------------------------------------------------------------------------
package sgp_pkg;

	// Sample path
	localparam int SAMPLE_W    = 32;
	localparam int INPUT_SHIFT = 14;
	localparam int SCALED_W    = SAMPLE_W - INPUT_SHIFT;
	localparam int DIFF_W      = SCALED_W + 1;

	// History ring
	localparam int HIST_AW    = 10;
	localparam int HIST_DEPTH = 1 << HIST_AW;

	// Configuration
	localparam int COEF_W     = 19;
	localparam int COEF_FRAC  = 16;
	localparam int COEF_LIMIT = 131072;
	localparam int WIN_W      = 11;
	localparam int WIN_RESET  = 256;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COEF_W;

	localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

	// Resonator and arithmetic unit
	localparam int STATE_W    = 48;
	localparam int STATE_FRAC = 12;
	localparam int HALF_W     = STATE_W / 2;
	localparam int MCOEF_W    = STATE_W + 2;
	localparam int OPND_W     = MCOEF_W - HALF_W;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int ACC_W      = 2 * STATE_W + 2;
	localparam int POWER_W    = 63;

	// Alignment of a product before it enters the accumulator
	typedef logic [1:0] shift_t;
	localparam shift_t SH_0  = 2'd0;
	localparam shift_t SH_24 = 2'd1;
	localparam shift_t SH_25 = 2'd2;
	localparam shift_t SH_48 = 2'd3;

	// Per-cycle command to the multiply-accumulate unit
	typedef struct packed {
		logic   issue;
		shift_t shift;
		logic   neg;
		logic   load;
		logic   load_half;
	} mac_ctl_t;

endpackage

@@ rtl/sgp_channels.sv @@
// ----------------------------------------------------------------------------
// sgp_channels
// Valid/ready channels for samples in and power results out.
// ----------------------------------------------------------------------------
interface sgp_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sgp_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface sgp_result_if;
	logic                         valid;
	logic                         ready;
	logic [sgp_pkg::POWER_W-1:0]  power;
	logic                         saturated;

	modport source (output valid, output power, output saturated, input ready);
	modport sink (input valid, input power, input saturated, output ready);
endinterface

@@ rtl/sgp_history.sv @@
// ----------------------------------------------------------------------------
// sgp_history
// Ring of scaled samples: writes the new sample and reads the one a window
// earlier in the same cycle; unwritten entries read as zero via a fill count.
// ----------------------------------------------------------------------------
module sgp_history (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic signed [sgp_pkg::SCALED_W-1:0]   scaled,
	input  logic [sgp_pkg::WIN_W-1:0]             window,
	output logic signed [sgp_pkg::SCALED_W-1:0]   old
);

	logic signed [sgp_pkg::SCALED_W-1:0] mem [sgp_pkg::HIST_DEPTH];

	logic [sgp_pkg::HIST_AW-1:0]         wp_q;
	logic [sgp_pkg::HIST_AW:0]           fill_q;
	logic [sgp_pkg::WIN_W-1:0]           n_clip;
	logic [sgp_pkg::HIST_AW-1:0]         rd_idx;
	logic                                zero_win;
	logic                                hit;
	logic signed [sgp_pkg::SCALED_W-1:0] rd_s1;
	logic signed [sgp_pkg::SCALED_W-1:0] scaled_s1;
	logic                                zero_s1;
	logic                                hit_s1;

	// Clip the window to the ring depth and locate the old entry
	always_comb begin
		n_clip   = (window > sgp_pkg::WIN_W'(sgp_pkg::HIST_DEPTH)) ?
			sgp_pkg::WIN_W'(sgp_pkg::HIST_DEPTH) : window;
		zero_win = (window == '0);
		rd_idx   = wp_q - n_clip[sgp_pkg::HIST_AW-1:0];
		hit      = fill_q[sgp_pkg::HIST_AW] || ({1'b0, rd_idx} < fill_q);
	end

	// Read before write, so a full-depth window sees the overwritten entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_s1       <= mem[rd_idx];
			mem[wp_q]   <= scaled;
			scaled_s1   <= scaled;
			zero_s1     <= zero_win;
			hit_s1      <= hit;
		end
	end

	// Advance the write pointer and count entries filled since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_q + 1'b1;
			if (!fill_q[sgp_pkg::HIST_AW]) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Zero window cancels the new sample; unwritten entries read as zero
	assign old = zero_s1 ? scaled_s1 : (hit_s1 ? rd_s1 : '0);

endmodule

@@ rtl/sgp_mac.sv @@
// ----------------------------------------------------------------------------
// sgp_mac
// Shared signed multiplier with a registered product and a wide accumulator
// that adds or subtracts the aligned product in the following cycle.
// ----------------------------------------------------------------------------
module sgp_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgp_pkg::mac_ctl_t                   ctl,
	input  logic signed [sgp_pkg::OPND_W-1:0]   op_a,
	input  logic signed [sgp_pkg::OPND_W-1:0]   op_b,
	output logic signed [sgp_pkg::ACC_W-1:0]    acc
);

	localparam logic signed [sgp_pkg::ACC_W-1:0] ACC_HALF =
		sgp_pkg::ACC_W'(1) <<< (sgp_pkg::COEF_FRAC - 1);

	logic signed [sgp_pkg::PROD_W-1:0] prod_s1;
	sgp_pkg::shift_t                   shift_s1;
	logic                              neg_s1;
	logic                              issue_s1;
	logic signed [sgp_pkg::ACC_W-1:0]  term_ext;
	logic signed [sgp_pkg::ACC_W-1:0]  term;
	logic signed [sgp_pkg::ACC_W-1:0]  acc_q;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1  <= op_a * op_b;
		shift_s1 <= ctl.shift;
		neg_s1   <= ctl.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
		end
	end

	// Align the product to its weight
	always_comb begin
		term_ext = sgp_pkg::ACC_W'(prod_s1);
		unique case (shift_s1)
			sgp_pkg::SH_0:  term = term_ext;
			sgp_pkg::SH_24: term = term_ext <<< 24;
			sgp_pkg::SH_25: term = term_ext <<< 25;
			sgp_pkg::SH_48: term = term_ext <<< 48;
			default:        term = term_ext;
		endcase
	end

	// Accumulate stage: preload the rounding half or zero, else add/subtract
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= ctl.load_half ? ACC_HALF : '0;
		end else if (issue_s1) begin
			acc_q <= neg_s1 ? (acc_q - term) : (acc_q + term);
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/sliding_goertzel_power.sv @@
// ----------------------------------------------------------------------------
// sliding_goertzel_power
// Sliding-window Goertzel tone power detector.
// Samples arrive on the samples channel and one power result per sample
// leaves on the results channel; a transaction completes on valid and ready.
// Registers coefficient (index 0) and window_length (index 1) are written
// through cfg_wr_en/cfg_index/cfg_data; the user must write them only while
// no sample is in flight; the block does not enforce this. Per sample the
// sequencer runs 14 partial products through one shared 26x26 multiplier
// plus accumulate and combine steps; it accepts no sample until the last
// one is done. The history ring is read and written in the accept cycle.
// Reset clears the resonator states and pointers; the history ring reads as
// zero until filled, tracked by a fill count, with no clearing pass.
// A stalled receiver holds the result register; the next sample is still
// processed and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_goertzel_power (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sgp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sgp_pkg::CFG_DATA_W-1:0]      cfg_data,
	sgp_sample_if.sink                          samples,
	sgp_result_if.source                        results
);

	// Sequencer steps
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CZ_LO  = 5'd1;
	localparam logic [4:0] ST_CZ_HI  = 5'd2;
	localparam logic [4:0] ST_CZ_ACC = 5'd3;
	localparam logic [4:0] ST_Z0     = 5'd4;
	localparam logic [4:0] ST_CM_LO  = 5'd5;
	localparam logic [4:0] ST_CM_HI  = 5'd6;
	localparam logic [4:0] ST_CM_ACC = 5'd7;
	localparam logic [4:0] ST_M      = 5'd8;
	localparam logic [4:0] ST_P1     = 5'd9;
	localparam logic [4:0] ST_P2     = 5'd10;
	localparam logic [4:0] ST_P3     = 5'd11;
	localparam logic [4:0] ST_P4     = 5'd12;
	localparam logic [4:0] ST_P5     = 5'd13;
	localparam logic [4:0] ST_P6     = 5'd14;
	localparam logic [4:0] ST_P7     = 5'd15;
	localparam logic [4:0] ST_P8     = 5'd16;
	localparam logic [4:0] ST_P9     = 5'd17;
	localparam logic [4:0] ST_PACC   = 5'd18;
	localparam logic [4:0] ST_FIN    = 5'd19;

	localparam int ZW = sgp_pkg::MCOEF_W + 2;
	localparam logic signed [ZW-1:0] Z_MAX = ZW'({1'b0, {(sgp_pkg::STATE_W-1){1'b1}}});
	localparam logic signed [ZW-1:0] Z_MIN = ~Z_MAX;
	localparam logic signed [sgp_pkg::COEF_W-1:0] C_MAX =
		sgp_pkg::COEF_W'(sgp_pkg::COEF_LIMIT);
	localparam logic signed [sgp_pkg::COEF_W-1:0] C_MIN = -C_MAX;
	localparam int P_TOP = sgp_pkg::POWER_W + 2 * sgp_pkg::HALF_W / 2;

	logic [4:0]                              step_q;
	logic                                    accept;
	logic                                    out_free;
	logic signed [sgp_pkg::COEF_W-1:0]       coef_q;
	logic [sgp_pkg::WIN_W-1:0]               win_q;
	logic signed [sgp_pkg::COEF_W-1:0]       c_q;
	logic                                    coef_clip;
	logic signed [sgp_pkg::COEF_W-1:0]       c_clamped;
	logic signed [sgp_pkg::SCALED_W-1:0]     scaled;
	logic signed [sgp_pkg::SCALED_W-1:0]     scaled_q;
	logic signed [sgp_pkg::SCALED_W-1:0]     old_sample;
	logic signed [sgp_pkg::DIFF_W-1:0]       diff;
	logic signed [sgp_pkg::STATE_W-1:0]      z1_q;
	logic signed [sgp_pkg::STATE_W-1:0]      z2_q;
	logic signed [sgp_pkg::MCOEF_W-1:0]      m_q;
	logic signed [sgp_pkg::MCOEF_W-1:0]      m_acc;
	logic signed [ZW-1:0]                    z_sum;
	logic signed [sgp_pkg::STATE_W-1:0]      z_new;
	logic                                    z_clip;
	logic                                    flag_q;
	logic signed [sgp_pkg::OPND_W-1:0]       c_op;
	logic signed [sgp_pkg::OPND_W-1:0]       z1_hi;
	logic signed [sgp_pkg::OPND_W-1:0]       z1_lo;
	logic signed [sgp_pkg::OPND_W-1:0]       z2_hi;
	logic signed [sgp_pkg::OPND_W-1:0]       z2_lo;
	logic signed [sgp_pkg::OPND_W-1:0]       m_hi;
	logic signed [sgp_pkg::OPND_W-1:0]       m_lo;
	sgp_pkg::mac_ctl_t                       mac_ctl;
	logic signed [sgp_pkg::OPND_W-1:0]       op_a;
	logic signed [sgp_pkg::OPND_W-1:0]       op_b;
	logic signed [sgp_pkg::ACC_W-1:0]        acc;
	logic                                    p_neg;
	logic                                    p_over;
	logic [sgp_pkg::POWER_W-1:0]             power_val;
	logic                                    out_valid_q;
	logic [sgp_pkg::POWER_W-1:0]             power_q;
	logic                                    sat_q;

	assign samples.ready = (step_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;

	// Scale the raw sample by the fixed arithmetic shift
	assign scaled = $signed(samples.sample[sgp_pkg::SAMPLE_W-1:sgp_pkg::INPUT_SHIFT]);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			win_q  <= sgp_pkg::WIN_W'(sgp_pkg::WIN_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sgp_pkg::REG_COEFFICIENT:   coef_q <= $signed(cfg_data[sgp_pkg::COEF_W-1:0]);
				sgp_pkg::REG_WINDOW_LENGTH: win_q  <= cfg_data[sgp_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the coefficient to +-2.0
	always_comb begin
		coef_clip = (coef_q > C_MAX) || (coef_q < C_MIN);
		if (coef_q > C_MAX) begin
			c_clamped = C_MAX;
		end else if (coef_q < C_MIN) begin
			c_clamped = C_MIN;
		end else begin
			c_clamped = coef_q;
		end
	end

	sgp_history u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.scaled (scaled),
		.window (win_q),
		.old    (old_sample)
	);

	// Split operands into multiplier halves
	always_comb begin
		c_op  = sgp_pkg::OPND_W'(c_q);
		z1_hi = sgp_pkg::OPND_W'($signed(z1_q[sgp_pkg::STATE_W-1:sgp_pkg::HALF_W]));
		z1_lo = sgp_pkg::OPND_W'(z1_q[sgp_pkg::HALF_W-1:0]);
		z2_hi = sgp_pkg::OPND_W'($signed(z2_q[sgp_pkg::STATE_W-1:sgp_pkg::HALF_W]));
		z2_lo = sgp_pkg::OPND_W'(z2_q[sgp_pkg::HALF_W-1:0]);
		m_hi  = sgp_pkg::OPND_W'($signed(m_q[sgp_pkg::MCOEF_W-1:sgp_pkg::HALF_W]));
		m_lo  = sgp_pkg::OPND_W'(m_q[sgp_pkg::HALF_W-1:0]);
	end

	// Decode the step into a multiply-accumulate command
	always_comb begin
		mac_ctl = '0;
		op_a    = '0;
		op_b    = '0;
		unique case (step_q)
			ST_IDLE: begin
				mac_ctl.load      = accept;
				mac_ctl.load_half = 1'b1;
			end
			ST_CZ_LO, ST_CM_LO: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_0;
				op_a = c_op;
				op_b = z1_lo;
			end
			ST_CZ_HI, ST_CM_HI: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_24;
				op_a = c_op;
				op_b = z1_hi;
			end
			ST_Z0: begin
				mac_ctl.load      = 1'b1;
				mac_ctl.load_half = 1'b1;
			end
			ST_M: begin
				mac_ctl.load  = 1'b1;
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_48;
				op_a = z1_hi;
				op_b = z1_hi;
			end
			ST_P1: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_25;
				op_a = z1_hi;
				op_b = z1_lo;
			end
			ST_P2: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_0;
				op_a = z1_lo;
				op_b = z1_lo;
			end
			ST_P3: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_48;
				op_a = z2_hi;
				op_b = z2_hi;
			end
			ST_P4: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_25;
				op_a = z2_hi;
				op_b = z2_lo;
			end
			ST_P5: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_0;
				op_a = z2_lo;
				op_b = z2_lo;
			end
			ST_P6: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.neg   = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_48;
				op_a = m_hi;
				op_b = z2_hi;
			end
			ST_P7: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.neg   = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_24;
				op_a = m_hi;
				op_b = z2_lo;
			end
			ST_P8: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.neg   = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_24;
				op_a = m_lo;
				op_b = z2_hi;
			end
			ST_P9: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.neg   = 1'b1;
				mac_ctl.shift = sgp_pkg::SH_0;
				op_a = m_lo;
				op_b = z2_lo;
			end
			default: ;
		endcase
	end

	sgp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	// New resonator state: diff*2^12 + round(c*z1) - z2, clipped to 48 bits
	always_comb begin
		diff   = sgp_pkg::DIFF_W'(scaled_q) - sgp_pkg::DIFF_W'(old_sample);
		m_acc  = $signed(acc[sgp_pkg::MCOEF_W+sgp_pkg::COEF_FRAC-1:sgp_pkg::COEF_FRAC]);
		z_sum  = (ZW'(diff) <<< sgp_pkg::STATE_FRAC) + ZW'(m_acc) - ZW'(z2_q);
		z_clip = (z_sum > Z_MAX) || (z_sum < Z_MIN);
		if (z_sum > Z_MAX) begin
			z_new = Z_MAX[sgp_pkg::STATE_W-1:0];
		end else if (z_sum < Z_MIN) begin
			z_new = Z_MIN[sgp_pkg::STATE_W-1:0];
		end else begin
			z_new = z_sum[sgp_pkg::STATE_W-1:0];
		end
	end

	// Power: drop negative residue, saturate above the 63-bit integer range
	always_comb begin
		p_neg  = acc[sgp_pkg::ACC_W-1];
		p_over = |acc[sgp_pkg::ACC_W-2:P_TOP];
		if (p_neg) begin
			power_val = '0;
		end else if (p_over) begin
			power_val = '1;
		end else begin
			power_val = acc[P_TOP-1:sgp_pkg::HALF_W];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (step_q == ST_IDLE) begin
			if (accept) begin
				step_q <= ST_CZ_LO;
			end
		end else if (step_q == ST_FIN) begin
			if (out_free) begin
				step_q <= ST_IDLE;
			end
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// Resonator states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
		end else if (step_q == ST_Z0) begin
			z1_q <= z_new;
			z2_q <= z1_q;
		end
	end

	// Per-sample working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q      <= c_clamped;
			scaled_q <= scaled;
		end
		if (step_q == ST_M) begin
			m_q <= m_acc;
		end
	end

	// Clip flag: coefficient at accept, state at update; power overflow is added in the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (accept) begin
			flag_q <= coef_clip;
		end else if (step_q == ST_Z0) begin
			flag_q <= flag_q || z_clip;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == ST_FIN && out_free) begin
			power_q <= power_val;
			sat_q   <= flag_q || (p_over && !p_neg);
		end
	end

	assign results.valid     = out_valid_q;
	assign results.power     = power_q;
	assign results.saturated = sat_q;

	`ASSERT_ALWAYS(a_step_range, step_q <= ST_FIN, "sequencer step out of range")
	`ASSERT_IMPLIES(a_idle_no_issue, step_q == ST_IDLE, !mac_ctl.issue, "multiply issued while idle")
	`ASSERT_NEXT(a_state_hold, step_q != ST_Z0, $stable(z1_q), "resonator state changed off its step")
	`ASSERT_IMPLIES(a_result_from_fin, $rose(out_valid_q), $past(step_q == ST_FIN), "result loaded outside final step")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding Goertzel power detector. A scoreboard
// predicts the power and the saturation flag of every accepted sample from
// its own copy of the history ring and resonator states. Each result is
// compared in order. Directed corner samples and configurations come first.
// Random phases follow, including a resonance run that drives the states
// into clipping and the power into overflow, under varied idling, one long
// receiver hold-off and one full drain pause.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic [sgp_pkg::POWER_W-1:0] power;
	logic                        saturated;
} power_result_t;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
typedef enum int {SRC_NOISE, SRC_SQUARE, SRC_QUIET} sample_src_t;

class power_scoreboard;
	typedef logic signed [127:0] wide_t;

	logic signed [sgp_pkg::COEF_W-1:0]   coefficient;
	logic [sgp_pkg::WIN_W-1:0]           window_length;
	logic signed [sgp_pkg::SCALED_W-1:0] history [sgp_pkg::HIST_DEPTH];
	logic [sgp_pkg::HIST_AW-1:0]         write_ptr;
	wide_t                               newest;
	wide_t                               older;
	power_result_t                       expected_powers [$];
	int                                  errors;

	function new();
		coefficient   = '0;
		window_length = sgp_pkg::WIN_W'(sgp_pkg::WIN_RESET);
		foreach (history[i])
			history[i] = '0;
		write_ptr = '0;
		newest    = '0;
		older     = '0;
		errors    = 0;
	endfunction

	function void write_reg(logic [sgp_pkg::CFG_IDX_W-1:0] index,
		logic [sgp_pkg::CFG_DATA_W-1:0] data);
		case (index)
			sgp_pkg::REG_COEFFICIENT:   coefficient = data[sgp_pkg::COEF_W-1:0];
			sgp_pkg::REG_WINDOW_LENGTH: window_length = data[sgp_pkg::WIN_W-1:0];
			default: ;
		endcase
	endfunction

	// c*z in the state format, rounded half up
	function wide_t scale_by_coef(wide_t c, wide_t z);
		return (c * z + wide_t'(32768)) >>> sgp_pkg::COEF_FRAC;
	endfunction

	// Advance the ring and the resonator by one sample; return its tone power
	function power_result_t tone_power(logic signed [sgp_pkg::SAMPLE_W-1:0] raw);
		wide_t                               c;
		wide_t                               limit;
		wide_t                               diff;
		wide_t                               z0;
		wide_t                               sum;
		wide_t                               floor_power;
		wide_t                               state_max;
		wide_t                               power_max;
		logic signed [sgp_pkg::SCALED_W-1:0] scaled;
		logic signed [sgp_pkg::SCALED_W-1:0] old;
		int                                  span;
		logic [sgp_pkg::HIST_AW-1:0]         slot;
		power_result_t                       res;

		state_max     = (128'sd1 <<< (sgp_pkg::STATE_W - 1)) - 128'sd1;
		power_max     = (128'sd1 <<< sgp_pkg::POWER_W) - 128'sd1;
		limit         = wide_t'(sgp_pkg::COEF_LIMIT);
		res.saturated = 1'b0;

		// clamp the coefficient to +-2.0
		c = wide_t'(coefficient);
		if (c > limit) begin
			c = limit;
			res.saturated = 1'b1;
		end else if (c < -limit) begin
			c = -limit;
			res.saturated = 1'b1;
		end

		// read the window's oldest sample before the new one lands
		scaled = sgp_pkg::SCALED_W'(raw >>> sgp_pkg::INPUT_SHIFT);
		span   = (window_length > sgp_pkg::WIN_W'(sgp_pkg::HIST_DEPTH)) ?
			sgp_pkg::HIST_DEPTH : int'(window_length);
		slot   = write_ptr - span[sgp_pkg::HIST_AW-1:0];
		old    = (span == 0) ? scaled : history[slot];
		history[write_ptr] = scaled;
		write_ptr = write_ptr + 1'b1;

		// resonator update, clipped to the state range
		diff = wide_t'(scaled) - wide_t'(old);
		z0   = (diff <<< sgp_pkg::STATE_FRAC) + scale_by_coef(c, newest) - older;
		if (z0 > state_max) begin
			z0 = state_max;
			res.saturated = 1'b1;
		end else if (z0 < -state_max - 128'sd1) begin
			z0 = -state_max - 128'sd1;
			res.saturated = 1'b1;
		end
		older  = newest;
		newest = z0;

		// exact power, floored to an integer
		sum         = newest * newest + older * older - scale_by_coef(c, newest) * older;
		floor_power = sum >>> (2 * sgp_pkg::STATE_FRAC);
		if (floor_power < 0) begin
			res.power = '0;
		end else if (floor_power > power_max) begin
			res.power     = power_max[sgp_pkg::POWER_W-1:0];
			res.saturated = 1'b1;
		end else begin
			res.power = floor_power[sgp_pkg::POWER_W-1:0];
		end
		return res;
	endfunction

	function void note_sample(logic signed [sgp_pkg::SAMPLE_W-1:0] raw);
		expected_powers.push_back(tone_power(raw));
	endfunction

	function void check_result(logic [sgp_pkg::POWER_W-1:0] power, logic saturated);
		power_result_t exp_res;
		if (expected_powers.size() == 0) begin
			$error("result with no sample pending: power %0d saturated %0b", power, saturated);
			errors++;
			return;
		end
		exp_res = expected_powers.pop_front();
		if (power !== exp_res.power) begin
			$error("power: expected %0d, got %0d", exp_res.power, power);
			errors++;
		end
		if (saturated !== exp_res.saturated) begin
			$error("saturated: expected %0b, got %0b", exp_res.saturated, saturated);
			errors++;
		end
	endfunction

	function int pending();
		return expected_powers.size();
	endfunction
endclass

module tb_top;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 101;
	localparam int GROW_ITEMS    = 600;
	localparam int DUMP_ITEMS    = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 4000;
	localparam int PAD_W         = sgp_pkg::CFG_DATA_W - sgp_pkg::WIN_W;

	localparam logic [sgp_pkg::COEF_W-1:0] COEF_POS = sgp_pkg::COEF_W'(sgp_pkg::COEF_LIMIT);
	localparam logic [sgp_pkg::COEF_W-1:0] COEF_NEG = sgp_pkg::COEF_W'(-sgp_pkg::COEF_LIMIT);
	localparam logic [sgp_pkg::WIN_W-1:0]  WIN_FULL = sgp_pkg::WIN_W'(sgp_pkg::HIST_DEPTH);

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [sgp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sgp_pkg::CFG_DATA_W-1:0] cfg_data;

	sgp_sample_if sample_bus ();
	sgp_result_if result_bus ();

	power_scoreboard sb;

	int   send_idle = 0;
	int   stall_pct = 0;
	int   hold_left = 0;
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;

	sliding_goertzel_power dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_bus),
		.results   (result_bus)
	);

	always #1 clk = ~clk;

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			result_bus.ready <= 1'b0;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Mirror register writes, check results, then predict new samples
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.write_reg(cfg_index, cfg_data);
			if (result_bus.valid && result_bus.ready)
				sb.check_result(result_bus.power, result_bus.saturated);
			if (sample_bus.valid && sample_bus.ready)
				sb.note_sample(sample_bus.sample);
		end
	end

	// Abort when no transaction of any kind happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (cfg_wr_en || (sample_bus.valid && sample_bus.ready) ||
			    (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic set_idling(input idling_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle = 0;
				stall_pct <= 0;
			end
			IDLE_SENDER: begin
				send_idle = 81;
				stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				send_idle = 0;
				stall_pct <= 81;
			end
			default: begin
				send_idle = 23;
				stall_pct <= 23;
			end
		endcase
	endtask

	// Offer one sample; return at the falling edge after its transaction
	task automatic send_sample(input logic [sgp_pkg::SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			sample_bus.valid <= 1'b0;
			@(negedge clk);
		end
		sample_bus.valid  <= 1'b1;
		sample_bus.sample <= value;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic stop_sender();
		sample_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Write both registers once the block has gone idle
	task automatic apply_config(input logic [sgp_pkg::COEF_W-1:0] coef,
		input logic [sgp_pkg::WIN_W-1:0] win);
		logic [PAD_W-1:0] pad;
		stop_sender();
		wait_drained();
		pad = PAD_W'($urandom());
		cfg_wr_en <= 1'b1;
		cfg_index <= sgp_pkg::REG_COEFFICIENT;
		cfg_data  <= coef;
		@(negedge clk);
		cfg_index <= sgp_pkg::REG_WINDOW_LENGTH;
		cfg_data  <= {pad, win};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random_phase(input int p);
		logic [sgp_pkg::COEF_W-1:0]   coef;
		logic [sgp_pkg::WIN_W-1:0]    win;
		logic [sgp_pkg::SAMPLE_W-1:0] amp;
		logic [sgp_pkg::SAMPLE_W-1:0] value;
		sample_src_t                  src;
		int                           period;

		// pick a coefficient: extremes, out of range, or anywhere in range
		case ($urandom_range(9))
			0: coef = COEF_POS;
			1: coef = COEF_NEG;
			2: coef = $urandom_range(1) ?
				19'(sgp_pkg::COEF_LIMIT + $urandom_range(1, 131071)) :
				19'(-(sgp_pkg::COEF_LIMIT + $urandom_range(1, 131072)));
			default: coef = 19'($urandom_range(0, 2 * sgp_pkg::COEF_LIMIT) -
				sgp_pkg::COEF_LIMIT);
		endcase

		// pick a window: zero, full depth, beyond depth, or mostly short
		case ($urandom_range(9))
			0: win = '0;
			1: win = WIN_FULL;
			2: win = sgp_pkg::WIN_W'($urandom_range(sgp_pkg::HIST_DEPTH + 1, 2047));
			3: win = sgp_pkg::WIN_W'($urandom_range(1, sgp_pkg::HIST_DEPTH));
			default: win = sgp_pkg::WIN_W'($urandom_range(1, 64));
		endcase

		apply_config(coef, win);
		set_idling(idling_t'(p % 4));
		src    = sample_src_t'($urandom_range(2));
		period = $urandom_range(2, 40);
		amp    = $urandom();

		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k == PHASE_ITEMS / 2) begin
				// hold the receiver off while samples keep coming
				if (p == 0)
					hold_req <= ~hold_req;
				// pause until every result is out, then carry on
				if (p == 2) begin
					stop_sender();
					wait_drained();
				end
			end
			case (src)
				SRC_SQUARE: value = (((k / period) % 2) ? amp : ~amp) ^ $urandom_range(1023);
				SRC_QUIET:  value = $signed($urandom()) >>> $urandom_range(8, 31);
				default:    value = $urandom();
			endcase
			send_sample(value);
		end
	endtask

	initial begin
		sb = new();
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		sample_bus.valid  = 1'b0;
		sample_bus.sample = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset configuration, full-scale and zero samples
		set_idling(IDLE_NONE);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);

		// Coefficient +2.0, one-sample window
		apply_config(COEF_POS, 11'd1);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_3FFF);

		// Coefficient -2.0, zero window: no drive into the resonator
		apply_config(COEF_NEG, 11'd0);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_4000);
		send_sample(32'hFFFF_C000);

		// Coefficient above range, window of full depth
		apply_config(19'h3FFFF, WIN_FULL);
		send_sample(32'h1234_5678);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h5555_5555);

		// Most negative coefficient code, widest window code
		apply_config(19'h40000, 11'h7FF);
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);

		// Just outside the coefficient range on both sides
		apply_config(COEF_POS + 19'd1, WIN_FULL + 11'd1);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		apply_config(COEF_NEG - 19'd1, 11'd2);
		send_sample(32'h7FFF_0000);
		send_sample(32'h8000_FFFF);

		// Random phases, with a resonance run in the middle
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES / 2) begin
				// drive the Nyquist resonator until the states clip
				apply_config(COEF_NEG, 11'd1);
				set_idling(IDLE_NONE);
				for (int k = 0; k < GROW_ITEMS; k++)
					send_sample((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
				// drop the coefficient so the clipped states overflow the power
				apply_config('0, '0);
				for (int k = 0; k < DUMP_ITEMS; k++)
					send_sample($urandom());
			end
			run_random_phase(p);
		end

		stop_sender();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sgp_pkg.sv
rtl/sgp_channels.sv
rtl/sgp_history.sv
rtl/sgp_mac.sv
rtl/sliding_goertzel_power.sv
test/tb_top.sv
